// ===== rtl/core/rotary_knob_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary knob decoder assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ROTARY_KNOB_DECODER_TOP_MACROS_SVH
`define ROTARY_KNOB_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RKD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rkd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob decoder package
// Payload types, register indexes, widths and the quadrature step table.
// ----------------------------------------------------------------------------
package rkd_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int KNOB_POS_WIDTH = 16;
    localparam int TSS_WIDTH      = 9;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ROTATION_DEBOUNCE = 2'd0,
        CFG_BUTTON_DEBOUNCE   = 2'd1,
        CFG_LONG_PRESS        = 2'd2
    } cfg_idx_t;

    // Indexed by {previous_ab, new_ab}
    localparam dir_t STEP_TABLE [16] = '{
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
    };

    localparam logic [7:0]  ROT_DEBOUNCE_RESET = 8'd2;
    localparam logic [7:0]  BTN_DEBOUNCE_RESET = 8'd50;
    localparam logic [15:0] LONG_PRESS_RESET   = 16'd2000;

    typedef struct packed {
        logic pin_a_level;
        logic pin_b_level;
        logic button_level;
    } knob_in_t;

    typedef struct packed {
        logic               cw_step;
        logic               ccw_step;
        logic               short_press;
        logic               long_press;
        logic [1:0]         last_direction;
        logic signed [KNOB_POS_WIDTH-1:0] knob_position;
    } knob_out_t;

endpackage

// ===== rtl/core/rotary_knob_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob decoder
// Quadrature encoder and push-button decoder, one pin sample per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one tick's sample of encoder pins A and B and the
// active-low button; each produces exactly one output transfer carrying the
// step events, press events, the direction of this tick's valid transition
// and the wrapped half-step position. The block takes one sample per clock
// cycle when the output side keeps up; a sample lands in the input register,
// all decoder and debounce state is updated as it moves to the result
// register, from which the result is offered. The output register holds a
// finished result while the next sample waits in the input register, so a
// stall on the output side only backs up after both registers are full.
// Configuration registers are written through a plain write port and should
// only change while no sample is in flight.
// ----------------------------------------------------------------------------
`include "rotary_knob_decoder_top_macros.svh"

module rotary_knob_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rkd_pkg::knob_in_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rkd_pkg::knob_out_t                  out_data,
    input  logic                                cfg_write,
    input  logic [rkd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [rkd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import rkd_pkg::*;

    // Configuration registers
    logic [7:0]  rot_debounce_reg;
    logic [7:0]  btn_debounce_reg;
    logic [15:0] long_press_ms_reg;

    // Input stage and result stage
    logic      s1_valid_reg;
    knob_in_t  s1_data_reg;
    logic      out_valid_reg;
    knob_out_t out_data_reg;
    knob_out_t out_data_next;
    logic      advance;

    // Decoder state
    logic [1:0]                previous_ab_reg, previous_ab_next;
    logic [1:0]                sampled_ab_reg, sampled_ab_next;
    logic                      previous_button_reg, previous_button_next;
    logic [POSITION_WIDTH-1:0] position_reg, position_next;
    logic [TSS_WIDTH-1:0]      ticks_since_step_reg, ticks_since_step_next;
    logic                      press_registered_reg, press_registered_next;
    logic                      long_fired_reg, long_fired_next;
    logic [15:0]               held_ticks_reg, held_ticks_next;
    logic                      debounce_pending_reg, debounce_pending_next;
    logic [7:0]                debounce_ticks_reg, debounce_ticks_next;

    // Working signals for one tick
    logic [1:0]           ab;
    logic [TSS_WIDTH-1:0] tss_inc;
    logic                 ab_changed;
    logic                 rot_accept;
    dir_t                 step_dir;
    logic [15:0]          held_inc;

    // Move the sample to the result stage whenever the result slot is free
    // or being drained this cycle; accept a new sample into the freed slot.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- rotation ----------------
    assign ab         = {s1_data_reg.pin_a_level, s1_data_reg.pin_b_level};
    assign tss_inc    = (ticks_since_step_reg == {TSS_WIDTH{1'b1}}) ?
                        ticks_since_step_reg : ticks_since_step_reg + 1'b1;
    assign ab_changed = (ab != sampled_ab_reg);
    // A change counts only once the debounce window after the last step is over
    assign rot_accept = ab_changed &&
                        (tss_inc > {{(TSS_WIDTH-8){1'b0}}, rot_debounce_reg});
    assign step_dir   = rot_accept ? STEP_TABLE[{previous_ab_reg, ab}] : DIR_NONE;
    assign held_inc   = (held_ticks_reg == 16'hFFFF) ? held_ticks_reg : held_ticks_reg + 1'b1;

    always_comb
    begin
        previous_ab_next      = rot_accept ? ab : previous_ab_reg;
        sampled_ab_next       = ab;
        ticks_since_step_next = (step_dir != DIR_NONE) ? '0 : tss_inc;
        position_next         = position_reg;

        out_data_next                = '0;
        out_data_next.last_direction = step_dir;

        case (step_dir)
            DIR_CW:
            begin
                position_next         = position_reg + 1'b1;
                out_data_next.cw_step = !position_next[0];
            end
            DIR_CCW:
            begin
                position_next          = position_reg - 1'b1;
                out_data_next.ccw_step = !position_next[0];
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase

        // Sign-extend or truncate the position to the output width
        out_data_next.knob_position = KNOB_POS_WIDTH'($signed(position_next));

        // ---------------- button ----------------
        previous_button_next  = s1_data_reg.button_level;
        press_registered_next = press_registered_reg;
        long_fired_next       = long_fired_reg;
        held_ticks_next       = held_ticks_reg;
        debounce_pending_next = debounce_pending_reg;
        debounce_ticks_next   = debounce_ticks_reg;

        if (s1_data_reg.button_level)
        begin
            // Release: short press only if the long press never fired
            out_data_next.short_press = press_registered_reg && !long_fired_reg;
            press_registered_next     = 1'b0;
            debounce_pending_next     = 1'b0;
        end
        else if (press_registered_reg)
        begin
            if (!long_fired_reg)
            begin
                held_ticks_next = held_inc;
                if (held_inc >= long_press_ms_reg)
                begin
                    out_data_next.long_press = 1'b1;
                    long_fired_next          = 1'b1;
                end
            end
        end
        else
        begin
            if (debounce_pending_reg)
            begin
                debounce_ticks_next = (debounce_ticks_reg == 8'hFF) ?
                                      debounce_ticks_reg : debounce_ticks_reg + 1'b1;
            end
            else if (previous_button_reg)
            begin
                // Falling edge: start the debounce count
                debounce_pending_next = 1'b1;
                debounce_ticks_next   = '0;
            end
            if (debounce_pending_next && (debounce_ticks_next >= btn_debounce_reg))
            begin
                debounce_pending_next = 1'b0;
                press_registered_next = 1'b1;
                long_fired_next       = 1'b0;
                held_ticks_next       = '0;
            end
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_debounce_reg  <= ROT_DEBOUNCE_RESET;
            btn_debounce_reg  <= BTN_DEBOUNCE_RESET;
            long_press_ms_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROTATION_DEBOUNCE: rot_debounce_reg  <= cfg_data[7:0];
                CFG_BUTTON_DEBOUNCE:   btn_debounce_reg  <= cfg_data[7:0];
                CFG_LONG_PRESS:        long_press_ms_reg <= cfg_data[15:0];
                default:               rot_debounce_reg  <= rot_debounce_reg;
            endcase
        end
    end

    // Pipeline control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            previous_ab_reg      <= 2'b00;
            sampled_ab_reg       <= 2'b11;
            previous_button_reg  <= 1'b1;
            position_reg         <= '0;
            ticks_since_step_reg <= {TSS_WIDTH{1'b1}};
            press_registered_reg <= 1'b0;
            long_fired_reg       <= 1'b0;
            held_ticks_reg       <= '0;
            debounce_pending_reg <= 1'b0;
            debounce_ticks_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg        <= 1'b1;
                previous_ab_reg      <= previous_ab_next;
                sampled_ab_reg       <= sampled_ab_next;
                previous_button_reg  <= previous_button_next;
                position_reg         <= position_next;
                ticks_since_step_reg <= ticks_since_step_next;
                press_registered_reg <= press_registered_next;
                long_fired_reg       <= long_fired_next;
                held_ticks_reg       <= held_ticks_next;
                debounce_pending_reg <= debounce_pending_next;
                debounce_ticks_reg   <= debounce_ticks_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A clockwise full-step event always agrees with the direction reported alongside it
    `RKD_ASSERT_SAME(a_cw_dir, out_valid_reg && out_data_reg.cw_step, out_data_reg.last_direction == DIR_CW, "cw step without clockwise direction")
    `RKD_ASSERT_SAME(a_press_excl, out_valid_reg, !(out_data_reg.short_press && out_data_reg.long_press), "short and long press in one tick")
    `RKD_ASSERT_SAME(a_pend_vs_press, debounce_pending_reg, !press_registered_reg, "debounce pending while press registered")
    // A fresh step leaves a result waiting and restarts the step timer
    `RKD_ASSERT_NEXT(a_step_result, advance && (step_dir != DIR_NONE), out_valid_reg && (ticks_since_step_reg == '0), "step without result")

endmodule

// ===== tb/rotary_knob_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob decoder testbench
// Streams encoder and button samples into the decoder over valid/ready and
// checks every result transfer, field by field, against a cycle-free
// behavioral model of the decoder kept in this module. A short scripted
// sequence opens the run. Randomized phases follow under several register
// settings, including both extremes. The run ends with one long button hold
// under the longest button debounce that lets a long press fire.
// ----------------------------------------------------------------------------
module rotary_knob_decoder_top_test;
    import rkd_pkg::*;

    localparam int RESET_CYCLES    = 2;
    localparam int SETTLE_CYCLES   = 8;        // two-register pipe plus margin
    localparam int PHASE_ITEMS     = 200;
    localparam int RANDOM_PHASES   = 6;
    localparam int HOLD_LONG_TICKS = 100;
    localparam int HOLD_ITEMS      = 256 + HOLD_LONG_TICKS + 40;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int PRINT_LIMIT     = 100;

    // Index 3 maps to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Quadrature move for each {previous_ab, new_ab} pair.
    localparam dir_t QUAD_MOVE [16] = '{
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
    };

    // Clockwise walk of the pin pair, and the inverse lookup.
    localparam logic [1:0] CW_WALK [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
    localparam int         WALK_POS [4] = '{0, 3, 1, 2};

    localparam knob_out_t IDLE_RESULT = '0;
    localparam knob_out_t FIRST_CCW_RESULT = '{
        cw_step: 1'b0, ccw_step: 1'b0, short_press: 1'b0, long_press: 1'b0,
        last_direction: DIR_CCW, knob_position: -1
    };

    typedef enum logic {ROW_PINS, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        knob_in_t                   pins;
        logic [CFG_IDX_WIDTH-1:0]   index;
        logic [CFG_DATA_WIDTH-1:0]  value;
        logic                       typed;
        knob_out_t                  want;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    knob_in_t                   in_data;
    logic                       out_valid;
    logic                       out_ready;
    knob_out_t                  out_data;
    logic                       cfg_write;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // Decoder model: registers
    logic [7:0]                 cfg_rot_settle;
    logic [7:0]                 cfg_btn_settle;
    logic [15:0]                cfg_long_ticks;

    // Decoder model: state
    logic [1:0]                 enc_last_ab;
    logic [1:0]                 enc_seen_ab;
    logic                       btn_last;
    logic [POSITION_WIDTH-1:0]  half_steps;
    logic [TSS_WIDTH-1:0]       quiet_ticks;
    logic                       press_held;
    logic                       long_sent;
    logic [15:0]                hold_ticks;
    logic                       press_pending;
    logic [7:0]                 settle_ticks;

    knob_out_t                  pending_results [$];
    int                         mismatches;
    int                         results_seen;

    // Sender and receiver pacing
    int                         burst_left;
    int                         ready_left;
    logic                       ready_stall;

    // Pin pattern generator
    logic [1:0]                 gen_ab;
    int                         gen_walk;
    logic                       gen_cw;
    int                         gen_ab_dwell;
    logic                       gen_btn_up;
    int                         gen_btn_dwell;

    // Opening script. Only the first rows carry a typed result: reset state,
    // an illegal pin jump, and the first counter-clockwise half step.
    row_t script [29] = '{
        '{ROW_PINS,  3'b111, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b1, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b1, IDLE_RESULT},
        '{ROW_PINS,  3'b011, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b1, FIRST_CCW_RESULT},
        // change inside the debounce window, then idle, then a jump
        '{ROW_PINS,  3'b111, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b111, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b111, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b101, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        // upper data bits must be dropped: debounce becomes zero
        '{ROW_WRITE, 3'b000, CFG_ROTATION_DEBOUNCE, 16'h0100, 1'b0, IDLE_RESULT},
        // one full clockwise turn, a step per tick
        '{ROW_PINS,  3'b101, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b111, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b011, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        // zero button debounce and zero long-press time
        '{ROW_WRITE, 3'b000, CFG_BUTTON_DEBOUNCE,   16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_WRITE, 3'b000, CFG_LONG_PRESS,        16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        // quick press and release gives a short press
        '{ROW_WRITE, 3'b000, CFG_LONG_PRESS,        16'h0003, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        // bounce cancels a pending press, the next edge restarts the count
        '{ROW_WRITE, 3'b000, CFG_BUTTON_DEBOUNCE,   16'h0002, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b000, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        '{ROW_PINS,  3'b001, CFG_ROTATION_DEBOUNCE, 16'h0000, 1'b0, IDLE_RESULT},
        // write to the unused index must change nothing
        '{ROW_WRITE, 3'b000, CFG_UNUSED_INDEX,      16'hFFFF, 1'b0, IDLE_RESULT}
    };

    rotary_knob_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    task automatic reset_model();
        cfg_rot_settle = 8'd2;
        cfg_btn_settle = 8'd50;
        cfg_long_ticks = 16'd2000;
        enc_last_ab    = 2'b00;
        enc_seen_ab    = 2'b11;         // pins idle pulled up
        btn_last       = 1'b1;          // button released
        half_steps     = '0;
        quiet_ticks    = '1;            // no step seen yet: counter saturated
        press_held     = 1'b0;
        long_sent      = 1'b0;
        hold_ticks     = '0;
        press_pending  = 1'b0;
        settle_ticks   = '0;
    endtask

    // Advance the model by one tick and return the result of that tick.
    function automatic knob_out_t decode_tick(input knob_in_t pins);
        knob_out_t  res;
        logic [1:0] ab;
        dir_t       move;
        res = '0;
        ab  = {pins.pin_a_level, pins.pin_b_level};

        // Rotation: a change counts only outside the debounce window; a
        // rejected change is forgotten, an illegal jump only moves the base.
        if (quiet_ticks != '1)
            quiet_ticks++;
        if (ab != enc_seen_ab)
        begin
            if (quiet_ticks > cfg_rot_settle)
            begin
                move = QUAD_MOVE[{enc_last_ab, ab}];
                if (move != DIR_NONE)
                begin
                    quiet_ticks = '0;
                    res.last_direction = move;
                    if (move == DIR_CW)
                    begin
                        half_steps++;
                        res.cw_step = !half_steps[0];
                    end
                    else
                    begin
                        half_steps--;
                        res.ccw_step = !half_steps[0];
                    end
                end
                enc_last_ab = ab;
            end
            enc_seen_ab = ab;
        end

        // Button: debounce the falling edge, then time the hold.
        if (pins.button_level)
        begin
            res.short_press = press_held && !long_sent;
            press_held      = 1'b0;
            press_pending   = 1'b0;
        end
        else if (press_held)
        begin
            if (!long_sent)
            begin
                if (hold_ticks != '1)
                    hold_ticks++;
                if (hold_ticks >= cfg_long_ticks)
                begin
                    res.long_press = 1'b1;
                    long_sent      = 1'b1;
                end
            end
        end
        else
        begin
            if (press_pending)
            begin
                if (settle_ticks != '1)
                    settle_ticks++;
            end
            else if (btn_last)
            begin
                press_pending = 1'b1;
                settle_ticks  = '0;
            end
            if (press_pending && settle_ticks >= cfg_btn_settle)
            begin
                press_pending = 1'b0;
                press_held    = 1'b1;
                long_sent     = 1'b0;
                hold_ticks    = '0;
            end
        end
        btn_last = pins.button_level;

        res.knob_position = KNOB_POS_WIDTH'($signed(half_steps));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Pin pattern generator: mostly clean quadrature walks and button presses
    // timed around the current debounce and long-press settings, with some
    // random jumps and short bounces mixed in.
    // ------------------------------------------------------------------------
    function automatic knob_in_t next_pins();
        knob_in_t pins;
        int       pick;
        if (gen_ab_dwell == 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // jump anywhere, possibly an illegal transition
                gen_ab   = 2'($urandom_range(0, 3));
                gen_walk = WALK_POS[gen_ab];
            end
            else
            begin
                if (pick < 20)
                    gen_cw = !gen_cw;
                gen_walk = gen_cw ? (gen_walk + 1) % 4 : (gen_walk + 3) % 4;
                gen_ab   = CW_WALK[gen_walk];
            end
            // Hold just past the window most of the time, inside it some of
            // the time, and rarely long enough to saturate the step timer.
            pick = $urandom_range(0, 99);
            if (pick < 65)
                gen_ab_dwell = cfg_rot_settle + 1 + $urandom_range(0, 2);
            else if (pick < 97)
                gen_ab_dwell = $urandom_range(1, cfg_rot_settle + 1);
            else
                gen_ab_dwell = $urandom_range(cfg_rot_settle + 2, 540);
        end
        gen_ab_dwell--;

        if (gen_btn_dwell == 0)
        begin
            gen_btn_up = !gen_btn_up;
            if (gen_btn_up)
                gen_btn_dwell = $urandom_range(1, 8);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    gen_btn_dwell = $urandom_range(1, 2);
                else if (pick < 55)
                    gen_btn_dwell = cfg_btn_settle + 1 + $urandom_range(0, 2);
                else if (pick < 85 && cfg_long_ticks <= 200)
                    gen_btn_dwell = cfg_btn_settle + cfg_long_ticks + $urandom_range(0, 3);
                else
                    gen_btn_dwell = $urandom_range(1, cfg_btn_settle + 6);
            end
        end
        gen_btn_dwell--;

        pins.pin_a_level  = gen_ab[1];
        pins.pin_b_level  = gen_ab[0];
        pins.button_level = gen_btn_up;
        return pins;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one sample and hold it until the transfer. Bursts of random
    // length are separated by random gaps; some bursts run long with no gap.
    task automatic send_pins(input knob_in_t pins, input logic typed, input knob_out_t want);
        knob_out_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 96 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= pins;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        predicted = decode_tick(pins);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every expected result has been taken.
    // Start a fresh burst afterwards so valid is not lowered twice.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        burst_left = $urandom_range(1, 24);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_ROTATION_DEBOUNCE: cfg_rot_settle = value[7:0];
            CFG_BUTTON_DEBOUNCE:   cfg_btn_settle = value[7:0];
            CFG_LONG_PRESS:        cfg_long_ticks = value[15:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare each result transfer with the oldest expectation, then pick
    // the next ready level from a run-length pattern of stalls and open runs.
    always @(posedge clk)
    begin : collect
        knob_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.cw_step !== want.cw_step)
                        report_mismatch($sformatf("result %0d cw_step %b, want %b",
                            results_seen, out_data.cw_step, want.cw_step));
                    if (out_data.ccw_step !== want.ccw_step)
                        report_mismatch($sformatf("result %0d ccw_step %b, want %b",
                            results_seen, out_data.ccw_step, want.ccw_step));
                    if (out_data.short_press !== want.short_press)
                        report_mismatch($sformatf("result %0d short_press %b, want %b",
                            results_seen, out_data.short_press, want.short_press));
                    if (out_data.long_press !== want.long_press)
                        report_mismatch($sformatf("result %0d long_press %b, want %b",
                            results_seen, out_data.long_press, want.long_press));
                    if (out_data.last_direction !== want.last_direction)
                        report_mismatch($sformatf("result %0d last_direction %0d, want %0d",
                            results_seen, out_data.last_direction, want.last_direction));
                    if (out_data.knob_position !== want.knob_position)
                        report_mismatch($sformatf("result %0d knob_position %0d, want %0d",
                            results_seen, out_data.knob_position, want.knob_position));
                end
            end
            if (ready_left == 0)
            begin
                ready_stall = !ready_stall;
                if (ready_stall)
                    ready_left = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    ready_left = $urandom_range(50, 150);
                else
                    ready_left = $urandom_range(1, 20);
            end
            ready_left--;
            out_ready <= !ready_stall;
        end
    end

    // Hard stop if the run hangs.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        knob_in_t pins;
        int       phase;
        int       i;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        mismatches    = 0;
        results_seen  = 0;
        burst_left    = 0;
        ready_left    = 0;
        ready_stall   = 1'b1;
        gen_ab        = 2'b11;
        gen_walk      = WALK_POS[2'b11];
        gen_cw        = 1'b1;
        gen_ab_dwell  = 0;
        gen_btn_up    = 1'b0;
        gen_btn_dwell = 0;
        reset_model();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the opening script; register writes wait for an idle block.
        foreach (script[r])
        begin
            if (script[r].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(script[r].index, script[r].value);
            end
            else
                send_pins(script[r].pins, script[r].typed, script[r].want);
        end

        // Random phases: the low extremes first, then random small settings,
        // then the high extremes with every data bit set.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            if (phase == 0)
            begin
                write_reg(CFG_ROTATION_DEBOUNCE, {8'($urandom), 8'd0});
                write_reg(CFG_BUTTON_DEBOUNCE, {8'($urandom), 8'd0});
                write_reg(CFG_LONG_PRESS, 16'd1);
            end
            else if (phase == RANDOM_PHASES - 1)
            begin
                write_reg(CFG_ROTATION_DEBOUNCE, 16'hFFFF);
                write_reg(CFG_BUTTON_DEBOUNCE, 16'hFFFF);
                write_reg(CFG_LONG_PRESS, 16'hFFFF);
            end
            else
            begin
                write_reg(CFG_ROTATION_DEBOUNCE, {8'($urandom), 8'($urandom_range(0, 6))});
                write_reg(CFG_BUTTON_DEBOUNCE, {8'($urandom), 8'($urandom_range(0, 12))});
                write_reg(CFG_LONG_PRESS, 16'($urandom_range(1, 40)));
            end
            gen_ab_dwell  = 0;
            gen_btn_dwell = 0;
            repeat (PHASE_ITEMS)
            begin
                // now and then hold off until the decoder has caught up
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_pins(next_pins(), 1'b0, IDLE_RESULT);
            end
        end

        // Long hold under the longest button debounce: shorten the long-press
        // time, release first so the falling edge is seen, keep the button
        // down until the long press fires, then release again. The encoder
        // keeps moving.
        drain_results();
        write_reg(CFG_LONG_PRESS, 16'(HOLD_LONG_TICKS));
        for (i = 0; i < HOLD_ITEMS + 7; i++)
        begin
            pins = next_pins();
            pins.button_level = (i < 3 || i >= HOLD_ITEMS + 3);
            send_pins(pins, 1'b0, IDLE_RESULT);
        end

        // Wait for the last results, then give a stray result time to show.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
